// ===== rtl/core/eabs_pkg.sv =====
package eabs_pkg;

    // Grid geometry
    localparam int MAX_COLS = 512;
    localparam int MAX_ROWS = 512;
    localparam int COL_AW   = $clog2(MAX_COLS);
    localparam int COL_CW   = COL_AW + 1;
    localparam int CFG_W    = 10;
    localparam int ROW_W    = CFG_W;
    localparam int POS_W    = 9;

    // Sample and result widths
    localparam int SAMPLE_W = 8;
    localparam int WORD_W   = 2 * SAMPLE_W;
    localparam int COLUMN_W = 3 * SAMPLE_W;
    localparam int MEAN_W   = 16;
    localparam logic [MEAN_W-1:0] MEAN_MAX = 16'hFF00;

    // Divider by a small constant count: sum * 256 + count / 2, then a
    // reciprocal multiply for counts of three, six and nine.
    localparam int FRAC_W    = 8;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int NUM_W     = SUM_W + FRAC_W;
    localparam int RECIP_W   = 21;
    localparam int PROD_W    = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = 21'd1398102;
    localparam int RECIP3_SH = 22;
    localparam logic [RECIP_W-1:0] RECIP9 = 21'd1864136;
    localparam int RECIP9_SH = 24;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Stream payload widths
    localparam int OUT_BITS    = 2 * POS_W + MEAN_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [0:0] {
        KIND_SAMPLE = 1'b0,
        KIND_FLUSH  = 1'b1
    } t_kind;

    // One window column: upper, middle and current bytes from high to low.
    typedef logic [COLUMN_W-1:0] t_column;

    typedef struct packed {
        logic             wr;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } t_cfg;

    // Work for one accepted item: up to two results sharing one window.
    // Job A uses k0, k1, k2; job B uses k1, k2 and has no right column.
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col_a;
        logic [POS_W-1:0] col_b;
        logic             a_en;
        logic             b_en;
        logic             a_left;
        logic             a_right;
        logic             b_left;
        logic             top_ok;
        logic             bot_ok;
        logic             last;
        t_column          k0;
        t_column          k1;
        t_column          k2;
    } t_entry;

endpackage

// ===== rtl/core/eabs_front.sv =====
module eabs_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  eabs_pkg::t_cfg                  i_cfg,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [0:0]                      i_kind,
    input  logic [eabs_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [eabs_pkg::QUEUE_CW-1:0]   i_q_count,
    output logic                            o_push,
    output eabs_pkg::t_entry                o_entry
);
    import eabs_pkg::*;

    typedef struct packed {
        logic                sample_ok;
        logic                flush_ok;
        logic                push;
        logic [COL_AW-1:0]   addr;
        logic [SAMPLE_W-1:0] sample;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col_a;
        logic [POS_W-1:0]    col_b;
        logic                a_en;
        logic                b_en;
        logic                a_left;
        logic                a_right;
        logic                b_left;
        logic                top_ok;
        logic                last;
    } t_stage;

    logic [ROW_W-1:0]    rows_eff;
    logic [COL_CW-1:0]   cols_eff;
    logic [ROW_W-1:0]    r_row;
    logic [COL_AW-1:0]   r_col;
    logic [ROW_W-1:0]    row_m1;
    logic [ROW_W-1:0]    rows_m1;
    logic [COL_AW-1:0]   col_m1;
    logic [COL_CW-1:0]   col_next;
    logic                col_is_end;
    logic                flush_phase;
    logic                accept;
    logic                is_sample;
    logic                is_flush;
    logic [QUEUE_CW:0]   q_need;
    t_stage              n_s1;
    t_stage              r_s1;

    logic [WORD_W-1:0]   r_lb [MAX_COLS];
    logic [WORD_W-1:0]   r_rd_a;
    logic [WORD_W-1:0]   r_rd_b;
    logic [COL_AW-1:0]   rd_addr_a;
    logic [COL_AW-1:0]   rd_addr_b;
    logic                lb_we;
    logic [WORD_W-1:0]   lb_wdata;

    t_column             r_win1;
    t_column             r_win2;
    logic [WORD_W-1:0]   r_prev_ctr;
    t_column             colw;

    // Clamp the configured size to the supported range.
    always_comb begin
        if (i_cfg.rows == '0) begin
            rows_eff = ROW_W'(1);
        end else if (32'(i_cfg.rows) > MAX_ROWS) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = i_cfg.rows;
        end
        if (i_cfg.cols == '0) begin
            cols_eff = COL_CW'(1);
        end else if (32'(i_cfg.cols) > MAX_COLS) begin
            cols_eff = COL_CW'(MAX_COLS);
        end else begin
            cols_eff = COL_CW'(i_cfg.cols);
        end
    end

    // Take an item only if the queue is sure to have room for it.
    assign q_need  = {1'b0, i_q_count} + (QUEUE_CW+1)'(r_s1.push);
    assign o_ready = q_need < (QUEUE_CW+1)'(QUEUE_DEPTH);
    assign accept  = i_valid && o_ready;

    // Classify the item against the raster position.
    assign row_m1      = r_row - ROW_W'(1);
    assign rows_m1     = rows_eff - ROW_W'(1);
    assign col_m1      = r_col - COL_AW'(1);
    assign col_next    = {1'b0, r_col} + COL_CW'(1);
    assign col_is_end  = (col_next == cols_eff);
    assign flush_phase = (r_row == rows_eff);
    assign is_sample   = accept && (t_kind'(i_kind) == KIND_SAMPLE) && !flush_phase;
    assign is_flush    = accept && (t_kind'(i_kind) == KIND_FLUSH) && flush_phase;

    always_comb begin
        n_s1           = '0;
        n_s1.sample_ok = is_sample;
        n_s1.flush_ok  = is_flush;
        n_s1.addr      = r_col;
        n_s1.sample    = i_sample;
        n_s1.col_b     = POS_W'(r_col);
        n_s1.b_left    = (r_col != '0);
        if (is_flush) begin
            n_s1.row     = rows_m1[POS_W-1:0];
            n_s1.col_a   = POS_W'(r_col);
            n_s1.a_en    = 1'b1;
            n_s1.a_left  = (r_col != '0);
            n_s1.a_right = !col_is_end;
            n_s1.top_ok  = (rows_eff > ROW_W'(1));
            n_s1.last    = col_is_end;
            n_s1.push    = 1'b1;
        end else begin
            n_s1.row     = row_m1[POS_W-1:0];
            n_s1.col_a   = POS_W'(col_m1);
            n_s1.a_en    = (r_row != '0) && (r_col != '0);
            n_s1.b_en    = (r_row != '0) && col_is_end;
            n_s1.a_left  = (r_col > COL_AW'(1));
            n_s1.a_right = 1'b1;
            n_s1.top_ok  = (r_row > ROW_W'(1));
            n_s1.push    = is_sample && (n_s1.a_en || n_s1.b_en);
        end
    end

    // Raster counters; a register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cfg.wr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (is_sample || is_flush) begin
            if (col_is_end) begin
                r_col <= '0;
                r_row <= is_flush ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= col_next[COL_AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    // Line buffer: one word per column, upper row in the high byte.
    // The word is rewritten in the cycle after its read, so reads of the
    // address being written take the new data.
    assign rd_addr_a = r_col;
    assign rd_addr_b = col_next[COL_AW-1:0];
    assign lb_we     = r_s1.sample_ok;
    assign lb_wdata  = {r_rd_a[SAMPLE_W-1:0], r_s1.sample};

    always_ff @(posedge i_clk) begin
        if (lb_we) begin
            r_lb[r_s1.addr] <= lb_wdata;
        end
        r_rd_a <= (lb_we && (r_s1.addr == rd_addr_a)) ? lb_wdata : r_lb[rd_addr_a];
        r_rd_b <= (lb_we && (r_s1.addr == rd_addr_b)) ? lb_wdata : r_lb[rd_addr_b];
    end

    // Window of the two previous columns, and the last flush center.
    assign colw = {r_rd_a, r_s1.sample};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win1     <= '0;
            r_win2     <= '0;
            r_prev_ctr <= '0;
        end else begin
            if (r_s1.sample_ok) begin
                r_win1 <= r_win2;
                r_win2 <= colw;
            end
            if (r_s1.flush_ok) begin
                r_prev_ctr <= r_rd_a;
            end
        end
    end

    // Hand the item to the queue.
    always_comb begin
        o_entry.row     = r_s1.row;
        o_entry.col_a   = r_s1.col_a;
        o_entry.col_b   = r_s1.col_b;
        o_entry.a_en    = r_s1.a_en;
        o_entry.b_en    = r_s1.b_en;
        o_entry.a_left  = r_s1.a_left;
        o_entry.a_right = r_s1.a_right;
        o_entry.b_left  = r_s1.b_left;
        o_entry.top_ok  = r_s1.top_ok;
        o_entry.bot_ok  = r_s1.sample_ok;
        o_entry.last    = r_s1.last;
        if (r_s1.flush_ok) begin
            o_entry.k0 = {r_prev_ctr, {SAMPLE_W{1'b0}}};
            o_entry.k1 = {r_rd_a, {SAMPLE_W{1'b0}}};
            o_entry.k2 = {r_rd_b, {SAMPLE_W{1'b0}}};
        end else begin
            o_entry.k0 = r_win1;
            o_entry.k1 = r_win2;
            o_entry.k2 = colw;
        end
    end
    assign o_push = r_s1.push;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_count < QUEUE_CW'(QUEUE_DEPTH)))
        else $error("front pushed into a full queue");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.wr |=> (r_row == '0) && (r_col == '0))
        else $error("register write did not restart the frame");

endmodule

// ===== rtl/core/eabs_queue.sv =====
module eabs_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  eabs_pkg::t_entry              i_entry,
    input  logic                          i_pop,
    output eabs_pkg::t_entry              o_entry,
    output logic                          o_nonempty,
    output logic [eabs_pkg::QUEUE_CW-1:0] o_count
);
    import eabs_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    assign o_entry    = r_mem[r_rd_ptr];
    assign o_nonempty = (r_count != '0);
    assign o_count    = r_count;

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

endmodule

// ===== rtl/core/eabs_back.sv =====
module eabs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  eabs_pkg::t_entry              i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [eabs_pkg::POS_W-1:0]    o_row,
    output logic [eabs_pkg::POS_W-1:0]    o_col,
    output logic [eabs_pkg::MEAN_W-1:0]   o_mean,
    output logic                          o_last
);
    import eabs_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
    } t_sum_stage;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
        logic [CNT_W-1:0]  cnt;
        logic [NUM_W-1:0]  num;
        logic [PROD_W-1:0] prod;
    } t_div_stage;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
        logic [MEAN_W-1:0] mean;
    } t_out_stage;

    logic              en;
    logic              issue;
    logic              use_a;
    logic              r_a_done;
    t_column           left_col;
    t_column           ctr_col;
    logic              left_ok;
    logic              right_ok;
    logic [1:0]        ncols;
    logic [1:0]        nrows;
    t_sum_stage        n_s1;
    t_sum_stage        r_s1;
    logic              r_s1_valid;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  mul_op;
    logic [RECIP_W-1:0] recip;
    t_div_stage        n_s2;
    t_div_stage        r_s2;
    logic              r_s2_valid;
    logic [MEAN_W-1:0] mean;
    t_out_stage        r_out;
    logic              r_out_valid;

    // Sum of the rows of one column that lie inside the grid.
    function automatic logic [SUM_W-1:0] column_sum(t_column c, logic top, logic bot);
        logic [SUM_W-1:0] s;
        s = SUM_W'(c[SAMPLE_W +: SAMPLE_W]);
        if (top) begin
            s = s + SUM_W'(c[2*SAMPLE_W +: SAMPLE_W]);
        end
        if (bot) begin
            s = s + SUM_W'(c[0 +: SAMPLE_W]);
        end
        return s;
    endfunction

    // The whole pipe moves when the output register is free or taken.
    assign en    = !r_out_valid || i_ready;
    assign issue = en && i_q_valid;
    assign use_a = i_entry.a_en && !r_a_done;
    assign o_pop = issue && (!use_a || !i_entry.b_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_done <= 1'b0;
        end else if (issue) begin
            r_a_done <= !o_pop;
        end
    end

    // Pick the job and sum its neighborhood.
    assign left_col = use_a ? i_entry.k0 : i_entry.k1;
    assign ctr_col  = use_a ? i_entry.k1 : i_entry.k2;
    assign left_ok  = use_a ? i_entry.a_left : i_entry.b_left;
    assign right_ok = use_a && i_entry.a_right;
    assign ncols    = 2'd1 + 2'(left_ok) + 2'(right_ok);
    assign nrows    = 2'd1 + 2'(i_entry.top_ok) + 2'(i_entry.bot_ok);

    always_comb begin
        n_s1.row  = i_entry.row;
        n_s1.col  = use_a ? i_entry.col_a : i_entry.col_b;
        n_s1.last = use_a && i_entry.last;
        n_s1.sum  = column_sum(ctr_col, i_entry.top_ok, i_entry.bot_ok);
        if (left_ok) begin
            n_s1.sum = n_s1.sum + column_sum(left_col, i_entry.top_ok, i_entry.bot_ok);
        end
        if (right_ok) begin
            n_s1.sum = n_s1.sum + column_sum(i_entry.k2, i_entry.top_ok, i_entry.bot_ok);
        end
        n_s1.cnt = CNT_W'(ncols) * CNT_W'(nrows);
    end

    // Rounded numerator and reciprocal multiply.
    assign num    = {r_s1.sum, {FRAC_W{1'b0}}} + NUM_W'(r_s1.cnt >> 1);
    assign mul_op = (r_s1.cnt == CNT_W'(6)) ? (num >> 1) : num;
    assign recip  = (r_s1.cnt == CNT_W'(9)) ? RECIP9 : RECIP3;

    always_comb begin
        n_s2.row  = r_s1.row;
        n_s2.col  = r_s1.col;
        n_s2.last = r_s1.last;
        n_s2.cnt  = r_s1.cnt;
        n_s2.num  = num;
        n_s2.prod = PROD_W'(mul_op) * PROD_W'(recip);
    end

    // Final quotient by count.
    always_comb begin
        case (r_s2.cnt) inside
            CNT_W'(2): mean = MEAN_W'(r_s2.num >> 1);
            CNT_W'(4): mean = MEAN_W'(r_s2.num >> 2);
            CNT_W'(3), CNT_W'(6): mean = r_s2.prod[RECIP3_SH +: MEAN_W];
            CNT_W'(9): mean = r_s2.prod[RECIP9_SH +: MEAN_W];
            default:   mean = MEAN_W'(r_s2.num);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1       <= n_s1;
            r_s2       <= n_s2;
            r_out.row  <= r_s2.row;
            r_out.col  <= r_s2.col;
            r_out.last <= r_s2.last;
            r_out.mean <= mean;
        end
    end

    assign o_valid = r_out_valid;
    assign o_row   = r_out.row;
    assign o_col   = r_out.col;
    assign o_mean  = r_out.mean;
    assign o_last  = r_out.last;

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.mean <= MEAN_MAX))
        else $error("smoothed height above the largest possible mean");

    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_done |-> (i_q_valid && i_entry.a_en && i_entry.b_en))
        else $error("second result pending without a two-result entry at the head");

endmodule

// ===== rtl/core/edge_aware_box_smoothing_top.sv =====
// 3x3 box smoothing of an 8-bit height grid streamed in raster order. Each result
// is the Q8.8 mean of the pixel's in-grid neighbors, rounded to nearest, tagged
// with its row and column; the final pixel of a frame carries tlast. After the
// last sample of a frame, send grid_cols flush transfers (tuser = 1) to drain the
// last row. One input transfer is accepted per clock; a sample that closes a row
// yields two results, and results leave at one per clock while m_axis_tready is
// high, so a four-entry queue between the classifying front end and the
// arithmetic back end absorbs the burst; s_axis_tready drops only when that
// queue, counting the entry still being written into it, is full. An input
// transfer passes the front-end line-buffer read register and the queue, then
// the back end's sum, reciprocal multiply and output registers, before its
// first result. The line buffer is a single 512-word memory with two read ports
// and one write port. Its contents need no clearing after reset, since no result
// uses a word written outside the current frame. Writing grid_rows or grid_cols
// (while the block is idle) restarts the frame at (0, 0).
module edge_aware_box_smoothing_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [eabs_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [7:0] height_sample
    input  logic [0:0]                         s_axis_tuser,  // [0] kind
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [eabs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // [8:0] out_row, [17:9] out_col,
                                                              // [33:18] smoothed_height, zero
    output logic                               m_axis_tlast,  // frame_last
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [eabs_pkg::PADDR_W-1:0]       paddr,
    input  logic [eabs_pkg::PDATA_W-1:0]       pwdata,
    output logic [eabs_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import eabs_pkg::*;

    logic              cfg_write;
    logic              cfg_index;
    logic [CFG_W-1:0]  r_rows;
    logic [CFG_W-1:0]  r_cols;
    t_cfg              cfg;
    logic              q_push;
    logic              q_pop;
    logic              q_nonempty;
    logic [QUEUE_CW-1:0] q_count;
    t_entry            push_entry;
    t_entry            head_entry;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic [MEAN_W-1:0] out_mean;

    // Register file: grid_rows at 0, grid_cols at 4.
    assign pready    = 1'b1;
    assign cfg_index = paddr[PADDR_W-1];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CFG_W'(MAX_ROWS);
            r_cols <= CFG_W'(MAX_COLS);
        end else if (cfg_write) begin
            if (cfg_index == REG_ROWS) begin
                r_rows <= pwdata[CFG_W-1:0];
            end else begin
                r_cols <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (cfg_index == REG_COLS) ? PDATA_W'(r_cols) : PDATA_W'(r_rows);

    assign cfg.wr   = cfg_write;
    assign cfg.rows = r_rows;
    assign cfg.cols = r_cols;

    eabs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_kind    (s_axis_tuser),
        .i_sample  (s_axis_tdata),
        .i_q_count (q_count),
        .o_push    (q_push),
        .o_entry   (push_entry)
    );

    eabs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_entry    (push_entry),
        .i_pop      (q_pop),
        .o_entry    (head_entry),
        .o_nonempty (q_nonempty),
        .o_count    (q_count)
    );

    eabs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_nonempty),
        .i_entry   (head_entry),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_row     (out_row),
        .o_col     (out_col),
        .o_mean    (out_mean),
        .o_last    (m_axis_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = OUT_TDATA_W'({out_mean, out_col, out_row});

endmodule

// ===== tb/sv/eabs_smoothing_checker.sv =====
// Watches both streams and the register port of the smoothing block. It keeps
// its own line buffers, window and raster counters, works out the pixels each
// accepted transfer must produce, and compares every output transfer with the
// oldest pixel still outstanding.
module eabs_smoothing_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream, observed only
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [eabs_pkg::SAMPLE_W-1:0]    s_axis_tdata,   // [7:0] height_sample
    input  logic [0:0]                       s_axis_tuser,   // [0] kind
    // Output stream, observed only
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [eabs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // [8:0] out_row, [17:9] out_col,
                                                             // [33:18] smoothed_height, zero
    input  logic                             m_axis_tlast,   // frame_last
    // Register port, observed only
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [eabs_pkg::PADDR_W-1:0]     paddr,
    input  logic [eabs_pkg::PDATA_W-1:0]     pwdata,
    input  logic [eabs_pkg::PDATA_W-1:0]     prdata,
    input  logic                             pready,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_results
);
    import eabs_pkg::*;

    localparam int PRINT_CAP = 50;

    typedef struct packed {
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic [MEAN_W-1:0] mean;
        logic              last;
    } t_pixel;

    // Shadow of the block's state.
    logic [SAMPLE_W-1:0] upper_line  [MAX_COLS];
    logic [SAMPLE_W-1:0] middle_line [MAX_COLS];
    t_column             win_cols    [3];
    int unsigned         row_pos;
    int unsigned         col_pos;
    logic [CFG_W-1:0]    rows_reg;
    logic [CFG_W-1:0]    cols_reg;

    t_pixel expected_pixels[$];
    int     fail_count   = 0;
    int     result_count = 0;

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what, input longint unsigned want,
                                   input longint unsigned got);
        if (fail_count < PRINT_CAP) begin
            $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                     $realtime, result_count, what, want, got);
        end
        fail_count++;
    endtask

    // A size of zero acts as one, and sizes above the buffers are clipped.
    function automatic int unsigned active_rows();
        if (rows_reg == '0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return rows_reg;
    endfunction

    function automatic int unsigned active_cols();
        if (cols_reg == '0) return 1;
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return cols_reg;
    endfunction

    // Column of the two stored rows; the current-row byte is left at zero.
    function automatic t_column stored_column(input int idx);
        if (idx < 0 || idx >= MAX_COLS) return '0;
        return {upper_line[idx], middle_line[idx], {SAMPLE_W{1'b0}}};
    endfunction

    // Rounded Q8.8 mean over the in-grid bytes of up to three columns.
    function automatic logic [MEAN_W-1:0] box_mean(
        input logic left_ok, input t_column lcol, input t_column ccol,
        input logic right_ok, input t_column rcol, input logic top_ok, input logic bot_ok
    );
        int unsigned sum;
        int unsigned cnt;
        t_column     cols [3];
        logic        use_col [3];
        sum        = 0;
        cnt        = 0;
        cols[0]    = lcol;
        cols[1]    = ccol;
        cols[2]    = rcol;
        use_col[0] = left_ok;
        use_col[1] = 1'b1;
        use_col[2] = right_ok;
        for (int k = 0; k < 3; k++) begin
            if (use_col[k]) begin
                sum += cols[k][2*SAMPLE_W-1:SAMPLE_W];
                cnt++;
                if (top_ok) begin
                    sum += cols[k][3*SAMPLE_W-1:2*SAMPLE_W];
                    cnt++;
                end
                if (bot_ok) begin
                    sum += cols[k][SAMPLE_W-1:0];
                    cnt++;
                end
            end
        end
        return MEAN_W'((sum * 256 + cnt / 2) / cnt);
    endfunction

    task automatic push_pixel(input int unsigned row, input int unsigned col,
                              input logic [MEAN_W-1:0] mean, input logic last);
        t_pixel px;
        px.row  = POS_W'(row);
        px.col  = POS_W'(col);
        px.mean = mean;
        px.last = last;
        expected_pixels.insert(expected_pixels.size(), px);
    endtask

    // Advances the shadow state by one accepted input transfer.
    task automatic predict_smoothing(input t_kind kind, input logic [SAMPLE_W-1:0] height);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned r;
        int unsigned c;
        logic        top_ok;
        nrows = active_rows();
        ncols = active_cols();
        r     = row_pos;
        c     = col_pos;
        if (kind == KIND_SAMPLE) begin
            // Samples are dropped while the last row drains.
            if (r == nrows) return;
            win_cols[0]    = win_cols[1];
            win_cols[1]    = win_cols[2];
            win_cols[2]    = {upper_line[c], middle_line[c], height};
            upper_line[c]  = middle_line[c];
            middle_line[c] = height;
            if (r >= 1) begin
                top_ok = (r >= 2);
                if (c >= 1) begin
                    push_pixel(r - 1, c - 1, box_mean(c >= 2, win_cols[0], win_cols[1],
                               1'b1, win_cols[2], top_ok, 1'b1), 1'b0);
                end
                // The row's last sample also closes its rightmost pixel.
                if (c == ncols - 1) begin
                    push_pixel(r - 1, c, box_mean(c >= 1, win_cols[1], win_cols[2],
                               1'b0, '0, top_ok, 1'b1), 1'b0);
                end
            end
            c++;
            if (c == ncols) begin
                c = 0;
                r++;
            end
        end else begin
            // Flushes count only once the frame's samples are all in.
            if (r != nrows) return;
            push_pixel(nrows - 1, c, box_mean(c >= 1, stored_column(int'(c) - 1),
                       stored_column(c), c + 1 < ncols, stored_column(c + 1),
                       nrows >= 2, 1'b0), c == ncols - 1);
            c++;
            if (c == ncols) begin
                c = 0;
                r = 0;
            end
        end
        row_pos = r;
        col_pos = c;
    endtask

    task automatic check_result();
        t_pixel want;
        result_count++;
        if (expected_pixels.size() == 0) begin
            report_mismatch("result with none outstanding, tdata", 0, m_axis_tdata);
            return;
        end
        want = expected_pixels.pop_front();
        if (m_axis_tdata[POS_W-1:0] != want.row)
            report_mismatch("out_row", want.row, m_axis_tdata[POS_W-1:0]);
        if (m_axis_tdata[2*POS_W-1:POS_W] != want.col)
            report_mismatch("out_col", want.col, m_axis_tdata[2*POS_W-1:POS_W]);
        if (m_axis_tdata[OUT_BITS-1:2*POS_W] != want.mean)
            report_mismatch("smoothed_height", want.mean, m_axis_tdata[OUT_BITS-1:2*POS_W]);
        if (m_axis_tlast != want.last)
            report_mismatch("frame_last", want.last, m_axis_tlast);
        if (m_axis_tdata[OUT_TDATA_W-1:OUT_BITS] != '0)
            report_mismatch("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:OUT_BITS]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_COLS; i++) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            for (int i = 0; i < 3; i++) win_cols[i] = '0;
            row_pos  = 0;
            col_pos  = 0;
            rows_reg = CFG_W'(MAX_ROWS);
            cols_reg = CFG_W'(MAX_COLS);
            expected_pixels.delete();
        end else begin
            // Any word-aligned register write restarts the frame; buffers are kept.
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
                if (paddr[PADDR_W-1:2] == REG_ROWS) rows_reg = pwdata[CFG_W-1:0];
                else cols_reg = pwdata[CFG_W-1:0];
                row_pos = 0;
                col_pos = 0;
            end
            // Register reads return the stored value.
            if (psel && penable && !pwrite && pready && paddr[1:0] == 2'b00) begin
                if (paddr[PADDR_W-1:2] == REG_ROWS) begin
                    if (prdata != PDATA_W'(rows_reg))
                        report_mismatch("grid_rows readback", rows_reg, prdata);
                end else if (prdata != PDATA_W'(cols_reg)) begin
                    report_mismatch("grid_cols readback", cols_reg, prdata);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_smoothing(t_kind'(s_axis_tuser[0]), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_pixels.size();
        o_results    <= result_count;
    end

endmodule

// ===== tb/sv/tb_edge_aware_box_smoothing_top.sv =====
// Stimulus and verdict for the 3x3 smoothing block; checking lives in the checker.
module tb_edge_aware_box_smoothing_top;
    import eabs_pkg::*;

    localparam int RANDOM_ITEMS  = 150;
    localparam int LIMIT_CYCLES  = 5_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int               fail_count;
    int               pending;
    int               results;
    logic             hold_request;
    int unsigned      cycle_count = 0;
    int unsigned      items_sent  = 0;
    int unsigned      frames_sent = 0;
    logic [CFG_W-1:0] cur_rows;
    logic [CFG_W-1:0] cur_cols;

    edge_aware_box_smoothing_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    eabs_smoothing_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d pixels outstanding", cycle_count, pending);
            $display("edge_aware_box_smoothing_top: mismatch");
            $finish;
        end
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Heights lean toward the extremes now and then.
    function automatic logic [SAMPLE_W-1:0] pick_height();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return SAMPLE_W'($urandom);
    endfunction

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] raw, input int unsigned cap);
        if (raw == '0) return 1;
        if (raw > cap) return cap;
        return raw;
    endfunction

    // Receiver: random ready pattern, one long hold-off on request.
    initial begin
        bit          hold_done;
        int unsigned pick;
        int unsigned span;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
                end else if (pick < 9) begin
                    span = pick_gap();
                    if (span == 0) span = 1;
                    m_axis_tready <= 1'b0;
                    repeat (span) @(posedge i_clk);
                end else begin
                    m_axis_tready <= 1'b1;
                    repeat (200) @(posedge i_clk);
                end
            end
        end
    end

    // One input transfer, optionally after an idle gap.
    task automatic send_item(input t_kind kind, input logic [SAMPLE_W-1:0] height,
                             input bit steady);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= height;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Stops sending and waits until every pixel has come back and the pipe is empty.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic reg_idx, input logic is_write,
                              input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= PADDR_W'({reg_idx, 2'b00});
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register writes, then readback of both registers.
    task automatic configure(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                             input bit write_rows, input bit write_cols);
        if (write_rows) begin
            apb_access(REG_ROWS, 1'b1, rows);
            cur_rows = rows;
        end
        if (write_cols) begin
            apb_access(REG_COLS, 1'b1, cols);
            cur_cols = cols;
        end
        apb_access(REG_ROWS, 1'b0, '0);
        apb_access(REG_COLS, 1'b0, '0);
    endtask

    // One frame at the current size; stray transfers of the wrong kind are mixed in.
    // A partial frame stops somewhere in the samples and sends no flushes.
    task automatic send_frame(input bit partial, output int unsigned counted);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned total;
        int unsigned n;
        bit          steady;
        nrows   = clamp_size(cur_rows, MAX_ROWS);
        ncols   = clamp_size(cur_cols, MAX_COLS);
        total   = nrows * ncols;
        n       = partial ? $urandom_range(0, total - 1) : total;
        steady  = ($urandom_range(0, 3) == 0);
        counted = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 2) send_item(KIND_FLUSH, SAMPLE_W'($urandom), steady);
            send_item(KIND_SAMPLE, pick_height(), steady);
            counted++;
        end
        if (!partial) begin
            for (int unsigned j = 0; j < ncols; j++) begin
                if ($urandom_range(0, 99) < 2) send_item(KIND_SAMPLE, pick_height(), steady);
                send_item(KIND_FLUSH, SAMPLE_W'($urandom), steady);
                counted++;
            end
            frames_sent++;
        end
    endtask

    initial begin
        int unsigned         counted;
        int unsigned         random_items;
        int unsigned         pick;
        bit                  restart_needed;
        bit                  partial;
        bit                  write_rows;
        bit                  write_cols;
        logic [CFG_W-1:0]    next_rows;
        logic [CFG_W-1:0]    next_cols;
        logic [SAMPLE_W-1:0] cross_pattern [9];
        int                  total_fails;

        cross_pattern = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_SAMPLE;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        hold_request  <= 1'b0;
        cur_rows       = CFG_W'(MAX_ROWS);
        cur_cols       = CFG_W'(MAX_COLS);
        restart_needed = 1'b0;
        random_items   = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, then first-row samples at the reset size (no pixels)
        // with an early flush that must be ignored.
        apb_access(REG_ROWS, 1'b0, '0);
        apb_access(REG_COLS, 1'b0, '0);
        send_item(KIND_SAMPLE, 8'd255, 1'b1);
        send_item(KIND_FLUSH, 8'd0, 1'b1);
        send_item(KIND_SAMPLE, 8'd0, 1'b1);
        wait_idle();

        // A 3x3 cross pattern; the write restarts the frame mid-row.
        configure(10'd3, 10'd3, 1'b1, 1'b1);
        for (int k = 0; k < 9; k++) send_item(KIND_SAMPLE, cross_pattern[k], 1'b0);
        send_item(KIND_FLUSH, 8'd0, 1'b0);
        send_item(KIND_SAMPLE, 8'd255, 1'b0);
        send_item(KIND_FLUSH, 8'd255, 1'b0);
        send_item(KIND_FLUSH, 8'd0, 1'b0);
        wait_idle();

        // Zero sizes act as a single pixel.
        configure('0, '0, 1'b1, 1'b1);
        send_item(KIND_SAMPLE, 8'd255, 1'b1);
        send_item(KIND_FLUSH, 8'd0, 1'b1);
        wait_idle();

        // Full-scale 2x2 grid.
        configure(10'd2, 10'd2, 1'b1, 1'b1);
        for (int k = 0; k < 4; k++) send_item(KIND_SAMPLE, 8'd255, 1'b1);
        send_item(KIND_FLUSH, 8'd0, 1'b1);
        send_item(KIND_FLUSH, 8'd0, 1'b1);
        wait_idle();

        // Oversized rows at one column; the receiver holds off for a long stretch meanwhile.
        configure('1, 10'd1, 1'b1, 1'b1);
        hold_request <= 1'b1;
        send_frame(1'b0, counted);
        wait_idle();
        // Oversized columns in a single row.
        configure(10'd1, '1, 1'b1, 1'b1);
        send_frame(1'b0, counted);

        // Random grids, mostly small, with stray and aborted frames.
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                next_rows = CFG_W'($urandom_range(1, 3));
                next_cols = CFG_W'($urandom_range(32, 160));
            end else begin
                next_rows = ($urandom_range(0, 99) < 5) ? '0 : CFG_W'($urandom_range(1, 6));
                next_cols = ($urandom_range(0, 99) < 5) ? '0 : CFG_W'($urandom_range(1, 12));
            end
            write_rows = (next_rows != cur_rows) || ($urandom_range(0, 3) == 0);
            write_cols = (next_cols != cur_cols) || ($urandom_range(0, 3) == 0);
            if (restart_needed && !write_rows && !write_cols) write_cols = 1'b1;
            if (write_rows || write_cols) begin
                wait_idle();
                configure(next_rows, next_cols, write_rows, write_cols);
            end
            partial = 1'b0;
            for (int f = $urandom_range(1, 3); f > 0; f--) begin
                partial = (f == 1) && ($urandom_range(0, 99) < 15);
                send_frame(partial, counted);
                random_items += counted;
            end
            restart_needed = partial;
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        total_fails = fail_count + pending;

        $display("Covered %0d full frames in %0d input transfers, %0d pixels checked.",
                 frames_sent, items_sent, results);
        $display("Grids ranged from one pixel to 512 rows or 512 columns, with stray kinds,",
                 " aborted frames and register readback.");
        if (total_fails == 0) begin
            $display("edge_aware_box_smoothing_top: match");
        end else begin
            $display("edge_aware_box_smoothing_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/eabs_pkg.sv
rtl/core/eabs_front.sv
rtl/core/eabs_queue.sv
rtl/core/eabs_back.sv
rtl/core/edge_aware_box_smoothing_top.sv
tb/sv/eabs_smoothing_checker.sv
tb/sv/tb_edge_aware_box_smoothing_top.sv
